// ===== hw/rtl/mi4_pkg.sv =====
// Shared types, codes and helpers for the 4x4 matrix inverse block.
`timescale 1ns / 1ps
package mi4_pkg;

   localparam logic [2:0] ACC_NONE  = 3'd0;
   localparam logic [2:0] ACC_T_SET = 3'd1;
   localparam logic [2:0] ACC_T_SUB = 3'd2;
   localparam logic [2:0] ACC_S_SET = 3'd3;
   localparam logic [2:0] ACC_S_ADD = 3'd4;
   localparam logic [2:0] ACC_S_SUB = 3'd5;
   localparam logic [2:0] ACC_D_SET = 3'd6;
   localparam logic [2:0] ACC_D_ADD = 3'd7;

   localparam logic [1:0] BSRC_ELEM = 2'd0;
   localparam logic [1:0] BSRC_T    = 2'd1;
   localparam logic [1:0] BSRC_COF  = 2'd2;

   typedef struct packed {
      logic       store_wr;
      logic [3:0] addr;
      logic       ld_a;
      logic       ld_b;
      logic [1:0] b_src;
      logic       mul_step;
      logic       mul_last;
      logic [2:0] acc_op;
      logic [3:0] cof_idx;
      logic       cof_wr;
      logic       cof_neg;
      logic       sing_eval;
      logic       div_init;
      logic       div_step;
      logic       emit;
      logic [3:0] out_idx;
      logic       out_last;
   } mi4_cmd_type;

   typedef struct packed {
      logic out_free;
   } mi4_status_type;

   // n-th index of 0..3 with x left out
   function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] x);
      skip_idx = (n < x) ? n : n + 2'd1;
   endfunction

endpackage

// ===== hw/rtl/mi4_dpath.sv =====
// Datapath: element store, serial multiplier, accumulators, cofactors, divider, output register.
`timescale 1ns / 1ps
module mi4_dpath #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mi4_pkg::mi4_cmd_type      cmd,
   output mi4_pkg::mi4_status_type   status,
   input  logic [3:0]                req_elem_index,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_value,
   input  logic [30:0]               det_threshold,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [3:0]                rsp_out_index,
   output logic signed [ELEM_WIDTH-1:0] rsp_out_value,
   output logic                      rsp_singular,
   output logic                      rsp_last
);
   import mi4_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int AW = 4 * W + 6;
   localparam int CW = 3 * W + 4;
   localparam int NW = CW + 2 * FRAC_BITS;
   localparam int TW = 31 + 3 * FRAC_BITS + 1;
   localparam int XW = (AW > TW) ? AW : TW;
   localparam int QW = ((NW > AW) ? NW : AW) + 1;

   logic [W-1:0]  store_ff [16];
   logic [CW-1:0] cof_ff [16];
   logic [W-1:0]  a_ff, a_in;
   logic [AW-1:0] b_ff, b_in, prod_ff, prod_in;
   logic [AW-1:0] t_ff, t_in, s_ff, s_in, d_ff, d_in;
   logic [AW-1:0] den_ff, den_in;
   logic          singular_ff, singular_in;
   logic [AW:0]   r_ff, r_in;
   logic [W-1:0]  lo_ff, lo_in, q_ff, q_in;
   logic          ovf_ff, ovf_in, neg_ff, neg_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [3:0]    rsp_index_ff;
   logic [W-1:0]  rsp_value_ff;
   logic          rsp_singular_ff, rsp_last_ff;

   logic [W-1:0]  elem;
   logic [CW-1:0] cof_rd, cof_abs;
   logic [AW-1:0] s_neg, d_abs;
   logic [NW-1:0] num, hi;
   logic [QW-1:0] hi_q;
   logic [AW:0]   r_shift, den_x;
   logic          ge;
   logic [W-1:0]  sat_val;

   localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINN = {1'b1, {(W-1){1'b0}}};

   assign elem    = store_ff[cmd.addr];
   assign cof_rd  = cof_ff[cmd.cof_idx];
   assign cof_abs = cof_rd[CW-1] ? -cof_rd : cof_rd;
   assign s_neg   = -s_ff;
   assign d_abs   = d_ff[AW-1] ? -d_ff : d_ff;
   assign num     = NW'(cof_abs) << (2 * FRAC_BITS);
   assign hi      = num >> W;
   assign hi_q    = QW'(hi);
   assign den_x   = {1'b0, den_ff};
   assign r_shift = {r_ff[AW-1:0], lo_ff[W-1]};
   assign ge      = r_shift >= den_x;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      prod_in = prod_ff;
      if (cmd.ld_a) begin
         a_in = elem;
      end else if (cmd.mul_step) begin
         a_in = a_ff >> 1;
      end
      if (cmd.ld_b) begin
         prod_in = '0;
         unique case (cmd.b_src)
            BSRC_T:   b_in = t_ff;
            BSRC_COF: b_in = {{(AW-CW){cof_rd[CW-1]}}, cof_rd};
            default:  b_in = {{(AW-W){elem[W-1]}}, elem};
         endcase
      end else if (cmd.mul_step) begin
         b_in = b_ff << 1;
         // top bit of a carries negative weight
         if (a_ff[0]) begin
            prod_in = cmd.mul_last ? prod_ff - b_ff : prod_ff + b_ff;
         end
      end
   end

   always_comb begin
      t_in = t_ff;
      s_in = s_ff;
      d_in = d_ff;
      unique case (cmd.acc_op)
         ACC_T_SET: t_in = prod_ff;
         ACC_T_SUB: t_in = t_ff - prod_ff;
         ACC_S_SET: s_in = prod_ff;
         ACC_S_ADD: s_in = s_ff + prod_ff;
         ACC_S_SUB: s_in = s_ff - prod_ff;
         ACC_D_SET: d_in = prod_ff;
         ACC_D_ADD: d_in = d_ff + prod_ff;
         default: ;
      endcase
   end

   always_comb begin
      den_in      = den_ff;
      singular_in = singular_ff;
      r_in        = r_ff;
      lo_in       = lo_ff;
      q_in        = q_ff;
      ovf_in      = ovf_ff;
      neg_in      = neg_ff;
      if (cmd.sing_eval) begin
         den_in      = d_abs;
         singular_in = (d_ff == '0) ||
                       (XW'(d_abs) < (XW'(det_threshold) << (3 * FRAC_BITS)));
      end
      if (cmd.div_init) begin
         ovf_in = hi_q >= QW'(den_ff);
         r_in   = hi_q[AW:0];
         lo_in  = num[W-1:0];
         q_in   = '0;
         neg_in = cof_rd[CW-1] ^ d_ff[AW-1];
      end else if (cmd.div_step) begin
         r_in  = ge ? r_shift - den_x : r_shift;
         lo_in = lo_ff << 1;
         q_in  = {q_ff[W-2:0], ge};
      end
   end

   always_comb begin
      if (neg_ff) begin
         sat_val = (ovf_ff || q_ff > MINN) ? MINN : -q_ff;
      end else begin
         sat_val = (ovf_ff || q_ff[W-1]) ? MAXP : q_ff;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            store_ff[i] <= '0;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.store_wr) begin
            store_ff[req_elem_index] <= req_elem_value;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      prod_ff     <= prod_in;
      t_ff        <= t_in;
      s_ff        <= s_in;
      d_ff        <= d_in;
      den_ff      <= den_in;
      singular_ff <= singular_in;
      r_ff        <= r_in;
      lo_ff       <= lo_in;
      q_ff        <= q_in;
      ovf_ff      <= ovf_in;
      neg_ff      <= neg_in;
      if (cmd.cof_wr) begin
         cof_ff[cmd.cof_idx] <= cmd.cof_neg ? s_neg[CW-1:0] : s_ff[CW-1:0];
      end
      if (cmd.emit) begin
         rsp_index_ff    <= cmd.out_idx;
         rsp_value_ff    <= singular_ff ? '0 : sat_val;
         rsp_singular_ff <= singular_ff;
         rsp_last_ff     <= cmd.out_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_singular  = rsp_singular_ff;
   assign rsp_last      = rsp_last_ff;

   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_singular_ff) |-> (rsp_value_ff == '0))
      else $error("singular result with nonzero value");

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_index_ff == 4'hF))
      else $error("last flag on wrong index");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=>
         (rsp_valid_ff && $stable(rsp_value_ff) && $stable(rsp_index_ff)))
      else $error("waiting result changed before transfer");

endmodule

// ===== hw/rtl/mi4_ctrl.sv =====
// Controller: sequences cofactor products, determinant, threshold check, divisions and emits.
`timescale 1ns / 1ps
module mi4_ctrl #(
   parameter int ELEM_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_go,
   input  mi4_pkg::mi4_status_type status,
   output mi4_pkg::mi4_cmd_type    cmd
);
   import mi4_pkg::*;

   localparam int CNTW = (ELEM_WIDTH > 1) ? $clog2(ELEM_WIDTH) : 1;
   localparam logic [CNTW-1:0] CNT_LAST = CNTW'(ELEM_WIDTH - 1);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LDA   = 4'd1;
   localparam logic [3:0] ST_LDB   = 4'd2;
   localparam logic [3:0] ST_RUN   = 4'd3;
   localparam logic [3:0] ST_ACC   = 4'd4;
   localparam logic [3:0] ST_CWR   = 4'd5;
   localparam logic [3:0] ST_DLA   = 4'd6;
   localparam logic [3:0] ST_DLB   = 4'd7;
   localparam logic [3:0] ST_DRUN  = 4'd8;
   localparam logic [3:0] ST_DACC  = 4'd9;
   localparam logic [3:0] ST_SING  = 4'd10;
   localparam logic [3:0] ST_VINIT = 4'd11;
   localparam logic [3:0] ST_VRUN  = 4'd12;
   localparam logic [3:0] ST_EMIT  = 4'd13;

   logic [3:0]      state_ff, state_in;
   logic [3:0]      k_ff, k_in;
   logic [1:0]      m_ff, m_in, ph_ff, ph_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;

   logic [1:0] i_row, j_col, rr0, rr1, rr2, cp, cq, cm;
   logic [3:0] addr_a, addr_b;
   logic       req_fire;

   assign i_row = k_ff[3:2];
   assign j_col = k_ff[1:0];
   assign rr0 = skip_idx(2'd0, i_row);
   assign rr1 = skip_idx(2'd1, i_row);
   assign rr2 = skip_idx(2'd2, i_row);
   // 2x2 minor columns leave out column m of the 3x3 minor
   assign cp = skip_idx((m_ff == 2'd0) ? 2'd1 : 2'd0, j_col);
   assign cq = skip_idx((m_ff == 2'd2) ? 2'd1 : 2'd2, j_col);
   assign cm = skip_idx(m_ff, j_col);

   always_comb begin
      unique case (ph_ff)
         2'd0:    addr_a = {rr1, cp};
         2'd1:    addr_a = {rr1, cq};
         default: addr_a = {rr0, cm};
      endcase
      addr_b = (ph_ff == 2'd0) ? {rr2, cq} : {rr2, cp};
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      m_in     = m_ff;
      ph_in    = ph_ff;
      cnt_in   = cnt_ff;
      cmd          = '0;
      cmd.store_wr = req_fire;
      cmd.b_src    = BSRC_ELEM;
      cmd.acc_op   = ACC_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_go) begin
               k_in     = '0;
               m_in     = '0;
               ph_in    = '0;
               state_in = ST_LDA;
            end
         end
         ST_LDA: begin
            cmd.addr = addr_a;
            cmd.ld_a = 1'b1;
            state_in = ST_LDB;
         end
         ST_LDB: begin
            cmd.addr  = addr_b;
            cmd.ld_b  = 1'b1;
            cmd.b_src = (ph_ff == 2'd2) ? BSRC_T : BSRC_ELEM;
            cnt_in    = '0;
            state_in  = ST_RUN;
         end
         ST_RUN: begin
            cmd.mul_step = 1'b1;
            cmd.mul_last = (cnt_ff == CNT_LAST);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            unique case (ph_ff)
               2'd0:    cmd.acc_op = ACC_T_SET;
               2'd1:    cmd.acc_op = ACC_T_SUB;
               default: begin
                  unique case (m_ff)
                     2'd0:    cmd.acc_op = ACC_S_SET;
                     2'd1:    cmd.acc_op = ACC_S_SUB;
                     default: cmd.acc_op = ACC_S_ADD;
                  endcase
               end
            endcase
            if (ph_ff != 2'd2) begin
               ph_in    = ph_ff + 2'd1;
               state_in = ST_LDA;
            end else if (m_ff != 2'd2) begin
               ph_in    = '0;
               m_in     = m_ff + 2'd1;
               state_in = ST_LDA;
            end else begin
               state_in = ST_CWR;
            end
         end
         ST_CWR: begin
            cmd.cof_wr  = 1'b1;
            cmd.cof_idx = k_ff;
            cmd.cof_neg = k_ff[2] ^ k_ff[0];
            m_in        = '0;
            ph_in       = '0;
            k_in        = k_ff + 4'd1;
            state_in    = (k_ff == 4'd15) ? ST_DLA : ST_LDA;
         end
         ST_DLA: begin
            cmd.addr = k_ff;
            cmd.ld_a = 1'b1;
            state_in = ST_DLB;
         end
         ST_DLB: begin
            cmd.cof_idx = k_ff;
            cmd.ld_b    = 1'b1;
            cmd.b_src   = BSRC_COF;
            cnt_in      = '0;
            state_in    = ST_DRUN;
         end
         ST_DRUN: begin
            cmd.mul_step = 1'b1;
            cmd.mul_last = (cnt_ff == CNT_LAST);
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DACC;
            end
         end
         ST_DACC: begin
            cmd.acc_op = (k_ff == 4'd0) ? ACC_D_SET : ACC_D_ADD;
            if (k_ff == 4'd3) begin
               k_in     = '0;
               state_in = ST_SING;
            end else begin
               k_in     = k_ff + 4'd1;
               state_in = ST_DLA;
            end
         end
         ST_SING: begin
            cmd.sing_eval = 1'b1;
            state_in      = ST_VINIT;
         end
         ST_VINIT: begin
            // inverse(r,c) takes cofactor (c,r)
            cmd.cof_idx  = {k_ff[1:0], k_ff[3:2]};
            cmd.div_init = 1'b1;
            cnt_in       = '0;
            state_in     = ST_VRUN;
         end
         ST_VRUN: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit     = 1'b1;
               cmd.out_idx  = k_ff;
               cmd.out_last = (k_ff == 4'd15);
               k_in         = k_ff + 4'd1;
               state_in     = (k_ff == 4'd15) ? ST_IDLE : ST_VINIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         m_ff     <= '0;
         ph_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         m_ff     <= m_in;
         ph_ff    <= ph_in;
         cnt_ff   <= cnt_in;
      end
   end

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_go) |=> !req_ready)
      else $error("input taken right after go");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("emit into occupied output register");

   a_store_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.store_wr |-> (state_ff == ST_IDLE))
      else $error("element stored while busy");

endmodule

// ===== hw/rtl/matrix_inverse_4x4.sv =====
// Work: a load item is written to the element store when taken; a go item runs 148 products
//   of W steps (W = ELEM_WIDTH) on the one bit-serial shift-add multiplier, then the restoring
//   divider (W steps per result).
// Throughput: one inversion at a time; the sixteen results leave one per divide when taken.
// Reset: synchronous, active high; clears the element store to zero, threshold to 1, control.
// Top level: 4x4 fixed-point matrix inverse by cofactors with APB threshold register.
`timescale 1ns / 1ps
module matrix_inverse_4x4 #(
   parameter int ELEM_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [3:0]                   req_elem_index,
   input  logic signed [ELEM_WIDTH-1:0] req_elem_value,
   input  logic                         req_go,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [3:0]                   rsp_out_index,
   output logic signed [ELEM_WIDTH-1:0] rsp_out_value,
   output logic                         rsp_singular,
   output logic                         rsp_last,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);
   import mi4_pkg::*;

   logic [30:0]    thr_ff, thr_in;
   mi4_cmd_type    cmd;
   mi4_status_type status;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {1'b0, thr_ff} : '0;

   always_comb begin
      thr_in = thr_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         thr_in = csr_pwdata[30:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 31'd1;
      end else begin
         thr_ff <= thr_in;
      end
   end

   mi4_ctrl #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_go    (req_go),
      .status    (status),
      .cmd       (cmd)
   );

   mi4_dpath #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_elem_index (req_elem_index),
      .req_elem_value (req_elem_value),
      .det_threshold  (thr_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_index  (rsp_out_index),
      .rsp_out_value  (rsp_out_value),
      .rsp_singular   (rsp_singular),
      .rsp_last       (rsp_last)
   );

endmodule
